// File: rtl/ppp_pkg.sv
package ppp_pkg;

  localparam int DW   = 33;  // point minus origin
  localparam int PW   = 49;  // difference times one axis component
  localparam int SW   = 51;  // sum of three products
  localparam int AW   = 35;  // floored dot product, Q.14
  localparam int NW   = 52;  // numerator before division
  localparam int RW   = 53;  // divider remainder
  localparam int QMAX = 14;  // widest quotient the image limits can need
  localparam int CW   = 24;  // colour

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_FWD = 3'd3;
  localparam logic [2:0] REG_AXIS_RGT = 3'd4;
  localparam logic [2:0] REG_AXIS_UP  = 3'd5;
  localparam logic [2:0] REG_FOCAL    = 3'd6;

  typedef struct packed {
    logic [RW-1:0]   rem_c;
    logic [RW-1:0]   rem_r;
    logic [QMAX-1:0] q_c;
    logic [QMAX-1:0] q_r;
    logic [RW-1:0]   dvs;
    logic            neg_c;
    logic            neg_r;
    logic            keep;
    logic [CW-1:0]   colour;
    logic            valid;
  } div_t;

endpackage

// File: rtl/ppp_in_if.sv
interface ppp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [23:0]        point_colour;

  modport source (output valid, point_x, point_y, point_z, point_colour, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_colour, output ready);
endinterface

// File: rtl/ppp_out_if.sv
interface ppp_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_column;
  logic [9:0]  pixel_row;
  logic [23:0] pixel_colour;

  modport source (output valid, pixel_column, pixel_row, pixel_colour, input ready);
  modport sink   (input valid, pixel_column, pixel_row, pixel_colour, output ready);
endinterface

// File: rtl/ppp_div_cell.sv
module ppp_div_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ppp_pkg::div_t d_in,
  output ppp_pkg::div_t d_out
);
  import ppp_pkg::*;

  div_t          d_r, d_nxt;
  logic [RW-1:0] sh;

  // one restoring step on both lanes against the shifted divisor
  always_comb begin
    sh    = d_in.dvs << BIT;
    d_nxt = d_in;
    if (d_in.rem_c >= sh) begin
      d_nxt.rem_c    = d_in.rem_c - sh;
      d_nxt.q_c[BIT] = 1'b1;
    end
    if (d_in.rem_r >= sh) begin
      d_nxt.rem_r    = d_in.rem_r - sh;
      d_nxt.q_r[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

// File: rtl/perspective_point_projection_core.sv
// Perspective point projection: one point word is taken per clock while the
// output does not stall and, when it lies in front of the camera and lands
// inside the image, one pixel word comes out. Registered stages form the
// difference, the products, the three dot products, the two numerators and the
// range check; a chain of QB = clog2(max(IMAGE_WIDTH, IMAGE_HEIGHT) + 1) divider
// cells then produces one quotient bit each for column and row, and an output
// register holds the pixel. Points that fall behind the camera or outside the
// image produce no word. A stalled output stalls the whole pipe.
module perspective_point_projection_core #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720,
  parameter int IMAGE_WIDTH   = 1280,
  parameter int IMAGE_HEIGHT  = 720
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  ppp_in_if.sink      in_pt,
  ppp_out_if.source   out_px
);
  import ppp_pkg::*;

  localparam int IMAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QB   = $clog2(IMAX + 1);
  localparam logic [12:0] HALF_W = 13'(SCREEN_WIDTH / 2);
  localparam logic [12:0] HALF_H = 13'(SCREEN_HEIGHT / 2);

  // configuration
  logic [31:0] origin_r [3];
  logic [47:0] axis_r   [3];
  logic [15:0] focal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        origin_r[i] <= '0;
        axis_r[i]   <= '0;
      end
      focal_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_r[0] <= cfg_wdata[31:0];
        REG_ORIGIN_Y: origin_r[1] <= cfg_wdata[31:0];
        REG_ORIGIN_Z: origin_r[2] <= cfg_wdata[31:0];
        REG_AXIS_FWD: axis_r[0]   <= cfg_wdata;
        REG_AXIS_RGT: axis_r[1]   <= cfg_wdata;
        REG_AXIS_UP:  axis_r[2]   <= cfg_wdata;
        REG_FOCAL:    focal_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_px.ready;
  assign in_pt.ready = adv;

  // stage valids and colour pipe
  logic [4:0]    v_r;
  logic [CW-1:0] col_r [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_pt.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r[0] <= in_pt.point_colour;
      for (int i = 1; i < 5; i++) col_r[i] <= col_r[i-1];
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] d_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0] <= DW'(in_pt.point_x) - DW'($signed(origin_r[0]));
      d_r[1] <= DW'(in_pt.point_y) - DW'($signed(origin_r[1]));
      d_r[2] <= DW'(in_pt.point_z) - DW'($signed(origin_r[2]));
    end
  end

  // stage 2: nine products, axis k component j
  logic signed [15:0]   axc      [3][3];
  logic signed [PW-1:0] prod_nxt [3][3];
  logic signed [PW-1:0] prod_r   [3][3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        axc[k][j]      = axis_r[k][16*j +: 16];
        prod_nxt[k][j] = d_r[j] * axc[k][j];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) prod_r <= prod_nxt;
  end

  // stage 3: sums floored to Q.14
  logic signed [SW-1:0] sum [3];
  logic signed [AW-1:0] dot_r [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SW'(prod_r[k][0]) + SW'(prod_r[k][1]) + SW'(prod_r[k][2]);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) dot_r[k] <= sum[k][SW-1:16];
    end
  end

  // stage 4: numerator products
  logic signed [NW-1:0] hc_r, fb_r, hr_r, fc_r;
  logic                 front_r;
  logic [RW-1:0]        dvs4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      hc_r    <= $signed({1'b0, HALF_W}) * dot_r[0];
      hr_r    <= $signed({1'b0, HALF_H}) * dot_r[0];
      fb_r    <= $signed({1'b0, focal_r}) * dot_r[1];
      fc_r    <= $signed({1'b0, focal_r}) * dot_r[2];
      front_r <= !dot_r[0][AW-1] && (dot_r[0] != '0);
      dvs4_r  <= RW'(dot_r[0][AW-2:0]);
    end
  end

  // stage 5: numerators
  logic signed [NW-1:0] nc_r, nr_r;
  logic                 front5_r;
  logic [RW-1:0]        dvs5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      nc_r     <= hc_r + fb_r;
      nr_r     <= hr_r + fc_r;
      front5_r <= front_r;
      dvs5_r   <= dvs4_r;
    end
  end

  // stage 6: magnitudes and range check, loads the divider chain
  div_t          chain [QB+1];
  div_t          ent_nxt, ent_r;
  logic [NW-1:0] mag_c, mag_r;
  logic [RW-1:0] lim;
  always_comb begin
    mag_c = nc_r[NW-1] ? NW'(-nc_r) : NW'(nc_r);
    mag_r = nr_r[NW-1] ? NW'(-nr_r) : NW'(nr_r);
    lim   = dvs5_r << QB;
    ent_nxt.rem_c  = RW'(mag_c);
    ent_nxt.rem_r  = RW'(mag_r);
    ent_nxt.q_c    = '0;
    ent_nxt.q_r    = '0;
    ent_nxt.dvs    = dvs5_r;
    ent_nxt.neg_c  = nc_r[NW-1];
    ent_nxt.neg_r  = nr_r[NW-1];
    ent_nxt.keep   = front5_r && (RW'(mag_c) < lim) && (RW'(mag_r) < lim);
    ent_nxt.colour = col_r[4];
    ent_nxt.valid  = v_r[4];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (adv) begin
      ent_r <= ent_nxt;
    end
  end
  assign chain[0] = ent_r;

  for (genvar g = 0; g < QB; g++) begin : g_div
    ppp_div_cell #(.BIT(QB - 1 - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  // output register
  div_t fin;
  logic ok_c, ok_r;
  logic [10:0] ocol_r;
  logic [9:0]  orow_r;
  logic [CW-1:0] ocolour_r;
  assign fin  = chain[QB];
  assign ok_c = fin.neg_c ? (fin.q_c == '0) : (int'(fin.q_c) < IMAGE_WIDTH);
  assign ok_r = fin.neg_r ? (fin.q_r == '0) : (int'(fin.q_r) < IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid && fin.keep && ok_c && ok_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ocol_r    <= 11'(fin.q_c);
      orow_r    <= 10'(fin.q_r);
      ocolour_r <= fin.colour;
    end
  end

  assign out_px.valid        = out_valid_r;
  assign out_px.pixel_column = ocol_r;
  assign out_px.pixel_row    = orow_r;
  assign out_px.pixel_colour = ocolour_r;

  a_col_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid |-> int'(out_px.pixel_column) < IMAGE_WIDTH)
    else $error("column beyond image");
  a_row_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid |-> int'(out_px.pixel_row) < IMAGE_HEIGHT)
    else $error("row beyond image");
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    (fin.valid && fin.keep) |-> (fin.rem_c < fin.dvs) && (fin.rem_r < fin.dvs))
    else $error("divider remainder not reduced");
endmodule
